@@ sv/fit_policy_allocator_with_eviction_unit_assert.svh @@
// Assertion macros for the fit policy allocator.
`ifndef FIT_POLICY_ALLOCATOR_WITH_EVICTION_UNIT_ASSERT_SVH
`define FIT_POLICY_ALLOCATOR_WITH_EVICTION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

@@ sv/fpa_pkg.sv @@
// Shared types and codes of the fit policy allocator.
`timescale 1ns / 1ps
package fpa_pkg;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FILL,
    S_COUNT,
    S_RESULT
  } state_t;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_NEXT  = 2'd3;

  localparam logic [1:0] OUT_PLACED  = 2'd0;
  localparam logic [1:0] OUT_EVICTED = 2'd1;
  localparam logic [1:0] OUT_REJECT  = 2'd2;

  localparam logic CFG_FIT_POLICY = 1'b0;
  localparam logic CFG_MAX_SWAPS  = 1'b1;

  localparam logic [1:0] SWAPS_SAT = 2'd3;

  // Control of the hole tracker during a free map pass.
  typedef struct packed {
    logic init;
    logic sample;
    logic free_bit;
    logic last;
  } scan_ctrl_t;

endpackage

@@ sv/fpa_ram.sv @@
// Single write port, single registered read port memory.
`timescale 1ns / 1ps
module fpa_ram #(
  parameter int W = 1,
  parameter int D = 128
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/fpa_hole_track.sv @@
// Run tracker and fit-policy compare unit, fed one free map bit per cycle.
`timescale 1ns / 1ps
module fpa_hole_track #(
  parameter int AW = 7,
  parameter int LW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  fpa_pkg::scan_ctrl_t ctrl,
  input  logic [AW-1:0]      addr,
  input  logic [7:0]         need,
  input  logic [1:0]         policy,
  input  logic [AW-1:0]      nfp,
  output logic               found,
  output logic [AW-1:0]      where
);
  import fpa_pkg::*;

  logic          prev;
  logic [AW-1:0] run_s;
  logic [LW-1:0] run_len;
  logic          have;
  logic [AW-1:0] best_s;
  logic [LW-1:0] best_len;
  logic          have_wrap;
  logic [AW-1:0] wrap_s;

  logic [AW-1:0] cur_s, ev_s;
  logic [LW-1:0] cur_len, ev_len;
  logic          ev, fits, take, take_wrap;

  always_comb begin
    cur_s   = prev ? run_s : addr;
    cur_len = prev ? run_len + LW'(1) : LW'(1);
    // a run closes on a used unit after free ones, or at the last unit
    ev      = ctrl.sample && ((!ctrl.free_bit && prev) || (ctrl.free_bit && ctrl.last));
    ev_s    = ctrl.free_bit ? cur_s : run_s;
    ev_len  = ctrl.free_bit ? cur_len : run_len;
    fits    = ev && (int'(ev_len) >= int'(need));
    take      = 1'b0;
    take_wrap = 1'b0;
    case (policy)
      POL_FIRST: take = fits && !have;
      POL_BEST:  take = fits && (!have || ev_len < best_len);
      POL_WORST: take = fits && (!have || ev_len > best_len);
      POL_NEXT: begin
        take_wrap = fits && !have_wrap;
        take      = fits && !have && ((LW'(ev_s) + ev_len) > LW'(nfp));
      end
      default: take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      prev      <= 1'b0;
      have      <= 1'b0;
      have_wrap <= 1'b0;
    end else if (ctrl.sample) begin
      prev <= ctrl.free_bit;
      if (ctrl.free_bit) begin
        run_s   <= cur_s;
        run_len <= cur_len;
      end
      if (take) begin
        have     <= 1'b1;
        best_s   <= ev_s;
        best_len <= ev_len;
      end
      if (take_wrap) begin
        have_wrap <= 1'b1;
        wrap_s    <= ev_s;
      end
    end
  end

  assign found = have || have_wrap;
  assign where = have ? best_s : wrap_s;
endmodule

@@ sv/fit_policy_allocator_with_eviction_unit.sv @@
// Top level of the contiguous allocator with fit policies and eviction.
//
//  channel | signals                                   | handshake
//  in      | process_id request_size swaps_so_far      | in_valid / in_ready
//  out     | outcome placed_start evicted_* requeue    | out_valid / out_ready
//          | resident_count hole_count used_units      |
//  cfg     | cfg_index cfg_data                        | cfg_we, no wait
//
// A request makes one pass over the free map and resident table together, a
// fill or free of one unit per cycle, and a hole count pass over the free map;
// each pass reads through the single read port of its memory.
// A size zero request skips all three; one rejected on empty memory still
// makes the scan pass, but skips the fill and the hole count pass.
// After reset a clearing pass over all MEM_UNITS units runs before in_ready rises.
// in_ready is low while a request is worked on; a result waits in the output
// register until taken, and the next request may be accepted meanwhile.
`timescale 1ns / 1ps
module fit_policy_allocator_with_eviction_unit #(
  parameter int MEM_UNITS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] process_id,
  input  logic [7:0] request_size,
  input  logic [1:0] swaps_so_far,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] outcome,
  output logic [6:0] placed_start,
  output logic [7:0] evicted_id,
  output logic [7:0] evicted_size,
  output logic [1:0] evicted_swaps,
  output logic       requeue,
  output logic [7:0] resident_count,
  output logic [6:0] hole_count,
  output logic [7:0] used_units,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data
);
  import fpa_pkg::*;
  `include "fit_policy_allocator_with_eviction_unit_assert.svh"

  localparam int AW = $clog2(MEM_UNITS);
  localparam int UW = $clog2(MEM_UNITS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_UNITS - 1);

  typedef struct packed {
    logic          valid;
    logic [7:0]    id;
    logic [AW-1:0] start;
    logic [7:0]    size;
    logic [1:0]    swaps;
    logic [31:0]   age;
  } entry_t;

  state_t state, state_next;

  logic [1:0] fit_policy, max_swaps;

  logic [AW-1:0] cnt;
  logic          issue_on, rd_v, rd_last;
  logic [AW-1:0] rd_addr;

  logic [7:0] req_id, req_size;
  logic [1:0] req_sw;

  logic          fm_we, fm_wd, fm_q;
  logic [AW-1:0] fm_wa;
  logic          tb_we;
  logic [AW-1:0] tb_wa;
  entry_t        tb_wd, tb_q;

  logic          v_found, s_found;
  logic [AW-1:0] v_slot, v_start, s_slot;
  logic [7:0]    v_id, v_size;
  logic [1:0]    v_swaps;
  logic [31:0]   best_gap, gap;

  logic [AW-1:0] fill_addr;
  logic [7:0]    rem;
  logic          fill_val, fill_end;

  logic [31:0]   load_counter;
  logic [AW-1:0] next_fit_point;
  logic [UW-1:0] used_total, resident_total, hole_total, hc, hc_next;
  logic          cprev;

  logic [1:0] r_outcome, r_evs;
  logic [6:0] r_start;
  logic [7:0] r_evid, r_evsize;
  logic       r_req;
  logic [1:0] ns;

  scan_ctrl_t    hctl;
  logic          ht_found;
  logic [AW-1:0] ht_where;

  fpa_ram #(.W(1), .D(MEM_UNITS)) u_free_map (
    .clk(clk), .we(fm_we), .waddr(fm_wa), .wdata(fm_wd), .raddr(cnt), .rdata(fm_q)
  );

  fpa_ram #(.W($bits(entry_t)), .D(MEM_UNITS)) u_table (
    .clk(clk), .we(tb_we), .waddr(tb_wa), .wdata(tb_wd), .raddr(cnt), .rdata(tb_q)
  );

  fpa_hole_track #(.AW(AW), .LW(UW)) u_hole (
    .clk(clk), .rst(rst), .ctrl(hctl), .addr(rd_addr), .need(req_size),
    .policy(fit_policy), .nfp(next_fit_point), .found(ht_found), .where(ht_where)
  );

  assign in_ready = (state == S_IDLE);
  assign fill_end = (rem == 8'd1) || (fill_addr == LAST_ADDR);
  assign gap      = load_counter - tb_q.age;
  assign hc_next  = hc + UW'(fm_q && !cprev);
  assign ns       = (v_swaps == SWAPS_SAT) ? SWAPS_SAT : v_swaps + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    hctl       = '0;
    hctl.init  = (state == S_IDLE) && in_valid;
    hctl.sample   = (state == S_SCAN) && rd_v;
    hctl.free_bit = fm_q;
    hctl.last     = rd_last;
    fm_we = 1'b0;
    fm_wa = fill_addr;
    fm_wd = fill_val;
    tb_we = 1'b0;
    tb_wa = s_slot;
    tb_wd = '0;
    case (state)
      S_CLEAR: begin
        fm_we = 1'b1;
        fm_wa = cnt;
        fm_wd = 1'b1;
        tb_we = 1'b1;
        tb_wa = cnt;
        if (cnt == LAST_ADDR) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = (request_size == 8'd0) ? S_RESULT : S_SCAN;
      end
      S_SCAN: begin
        if (rd_v && rd_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (ht_found) begin
          tb_we       = 1'b1;
          tb_wd.valid = 1'b1;
          tb_wd.id    = req_id;
          tb_wd.start = ht_where;
          tb_wd.size  = req_size;
          tb_wd.swaps = req_sw;
          tb_wd.age   = load_counter;
          state_next  = S_FILL;
        end else if (v_found) begin
          tb_we      = 1'b1;
          tb_wa      = v_slot;
          state_next = S_FILL;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_FILL: begin
        fm_we = 1'b1;
        if (fill_end) state_next = S_COUNT;
      end
      S_COUNT: begin
        if (rd_v && rd_last) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= POL_FIRST;
      max_swaps  <= 2'd3;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIT_POLICY) fit_policy <= cfg_data;
      if (cfg_index == CFG_MAX_SWAPS)  max_swaps  <= cfg_data;
    end
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt            <= '0;
      issue_on       <= 1'b0;
      rd_v           <= 1'b0;
      out_valid      <= 1'b0;
      load_counter   <= '0;
      next_fit_point <= '0;
      used_total     <= '0;
      resident_total <= '0;
      hole_total     <= UW'(1);
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          cnt <= (cnt == LAST_ADDR) ? '0 : cnt + AW'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            req_id    <= process_id;
            req_size  <= request_size;
            req_sw    <= swaps_so_far;
            cnt       <= '0;
            issue_on  <= 1'b1;
            rd_v      <= 1'b0;
            v_found   <= 1'b0;
            s_found   <= 1'b0;
            r_outcome <= (request_size == 8'd0) ? OUT_REJECT : OUT_PLACED;
            r_start   <= '0;
            r_evid    <= '0;
            r_evsize  <= '0;
            r_evs     <= '0;
            r_req     <= 1'b0;
          end
        end
        S_SCAN, S_COUNT: begin
          // issue one read per cycle, consume the data in the cycle after
          rd_v    <= issue_on;
          rd_addr <= cnt;
          rd_last <= (cnt == LAST_ADDR);
          if (issue_on) begin
            if (cnt == LAST_ADDR) issue_on <= 1'b0;
            else cnt <= cnt + AW'(1);
          end
          if (state == S_SCAN && rd_v) begin
            if (tb_q.valid) begin
              if (!v_found || gap > best_gap) begin
                v_found  <= 1'b1;
                best_gap <= gap;
                v_slot   <= rd_addr;
                v_id     <= tb_q.id;
                v_start  <= tb_q.start;
                v_size   <= tb_q.size;
                v_swaps  <= tb_q.swaps;
              end
            end else if (!s_found) begin
              s_found <= 1'b1;
              s_slot  <= rd_addr;
            end
          end
          if (state == S_COUNT && rd_v) begin
            cprev <= fm_q;
            hc    <= hc_next;
            if (rd_last) hole_total <= hc_next;
          end
        end
        S_DECIDE: begin
          if (ht_found) begin
            fill_addr      <= ht_where;
            rem            <= req_size;
            fill_val       <= 1'b0;
            load_counter   <= load_counter + 32'd1;
            next_fit_point <= ht_where;
            used_total     <= used_total + UW'(req_size);
            resident_total <= resident_total + UW'(1);
            r_start        <= 7'(ht_where);
          end else if (v_found) begin
            fill_addr      <= v_start;
            rem            <= v_size;
            fill_val       <= 1'b1;
            used_total     <= used_total - UW'(v_size);
            resident_total <= resident_total - UW'(1);
            r_outcome      <= OUT_EVICTED;
            r_evid         <= v_id;
            r_evsize       <= v_size;
            r_evs          <= ns;
            r_req          <= (ns < max_swaps);
          end else begin
            r_outcome <= OUT_REJECT;
          end
        end
        S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          rem       <= rem - 8'd1;
          if (fill_end) begin
            cnt      <= '0;
            issue_on <= 1'b1;
            rd_v     <= 1'b0;
            hc       <= '0;
            cprev    <= 1'b0;
          end
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            outcome        <= r_outcome;
            placed_start   <= r_start;
            evicted_id     <= r_evid;
            evicted_size   <= r_evsize;
            evicted_swaps  <= r_evs;
            requeue        <= r_req;
            resident_count <= 8'(resident_total);
            hole_count     <= 7'(hole_total);
            used_units     <= 8'(used_total);
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

  `FPA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `FPA_ASSERT_NOW(a_fill_nonzero, state == S_FILL, rem != 8'd0)
  `FPA_ASSERT_NOW(a_used_bound, 1'b1, int'(used_total) <= MEM_UNITS)
  `FPA_ASSERT_NOW(a_resident_le_used, 1'b1, resident_total <= used_total)
endmodule

@@ bench/fit_policy_allocator_with_eviction_unit_tb.sv @@
// Self-checking bench for the allocator: queue-fed driver, monitor, allocation predictor.
`timescale 1ns / 1ps
module fit_policy_allocator_with_eviction_unit_tb;
  import fpa_pkg::*;

  typedef struct {
    logic [7:0] pid;
    logic [7:0] size;
    logic [1:0] swaps;
  } request_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [6:0] start;
    logic [7:0] ev_id;
    logic [7:0] ev_size;
    logic [1:0] ev_swaps;
    logic       requeue;
    logic [7:0] residents;
    logic [6:0] holes;
    logic [7:0] used;
  } alloc_result_t;

  localparam int UNITS = 128;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] process_id = '0;
  logic [7:0] request_size = '0;
  logic [1:0] swaps_so_far = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] outcome;
  logic [6:0] placed_start;
  logic [7:0] evicted_id;
  logic [7:0] evicted_size;
  logic [1:0] evicted_swaps;
  logic requeue;
  logic [7:0] resident_count;
  logic [6:0] hole_count;
  logic [7:0] used_units;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [1:0] cfg_data = '0;

  fit_policy_allocator_with_eviction_unit i_dut (.*);

  always #1 clk = ~clk;

  // Allocator shadow state.
  logic [1:0]  policy;
  logic [1:0]  swap_limit;
  bit          unit_free [UNITS];
  bit          slot_busy [UNITS];
  logic [7:0]  slot_pid [UNITS];
  int unsigned slot_start [UNITS];
  int unsigned slot_size [UNITS];
  logic [1:0]  slot_swaps [UNITS];
  logic [31:0] slot_age [UNITS];
  logic [31:0] placements;
  int unsigned resume_at;

  request_t      pending_reqs[$];
  alloc_result_t expected_results[$];
  int  mismatches = 0;
  bit  quiet_in = 0;    // sender pause flag
  bit  quiet_out = 0;   // no random idling
  int  hold_cycles = 0; // receiver hold-off
  bit  driving = 0;

  function automatic bit pick_hole(input int unsigned need, output int unsigned where);
    int unsigned u, s, len, best_s, best_len, wrap_s;
    bit have, have_wrap;
    u = 0; best_s = 0; best_len = 0; wrap_s = 0; have = 0; have_wrap = 0;
    while (u < UNITS) begin
      if (!unit_free[u]) begin
        u++;
        continue;
      end
      s = u;
      while (u < UNITS && unit_free[u]) u++;
      len = u - s;
      if (len < need) continue;
      case (policy)
        POL_FIRST: if (!have) begin have = 1; best_s = s; end
        POL_BEST: if (!have || len < best_len) begin
          have = 1; best_s = s; best_len = len;
        end
        POL_WORST: if (!have || len > best_len) begin
          have = 1; best_s = s; best_len = len;
        end
        default: begin
          if (!have_wrap) begin have_wrap = 1; wrap_s = s; end
          if (!have && s + len > resume_at) begin have = 1; best_s = s; end
        end
      endcase
    end
    if (!have && have_wrap) begin have = 1; best_s = wrap_s; end
    where = best_s;
    return have;
  endfunction

  function automatic alloc_result_t predict_alloc(input request_t r);
    alloc_result_t res;
    int unsigned where, k, victim, used, holes, cnt;
    logic [31:0] gap, best_gap;
    bit found, prev;
    logic [1:0] ns;
    res = '{default: '0};
    if (r.size == 0) begin
      res.outcome = OUT_REJECT;
    end else if (pick_hole(32'(r.size), where)) begin
      for (k = 0; k < r.size && where + k < UNITS; k++) unit_free[where + k] = 0;
      for (k = 0; k < UNITS; k++) if (!slot_busy[k]) begin
        slot_busy[k] = 1; slot_pid[k] = r.pid; slot_start[k] = where;
        slot_size[k] = 32'(r.size); slot_swaps[k] = r.swaps; slot_age[k] = placements;
        break;
      end
      placements++;
      resume_at = where;
      res.outcome = OUT_PLACED;
      res.start = where[6:0];
    end else begin
      found = 0; victim = 0; best_gap = 0;
      for (k = 0; k < UNITS; k++) if (slot_busy[k]) begin
        gap = placements - slot_age[k];
        if (!found || gap > best_gap) begin found = 1; victim = k; best_gap = gap; end
      end
      if (!found) begin
        res.outcome = OUT_REJECT;
      end else begin
        ns = (slot_swaps[victim] < SWAPS_SAT) ? slot_swaps[victim] + 2'd1 : SWAPS_SAT;
        for (k = 0; k < slot_size[victim] && slot_start[victim] + k < UNITS; k++)
          unit_free[slot_start[victim] + k] = 1;
        res.outcome = OUT_EVICTED;
        res.ev_id = slot_pid[victim];
        res.ev_size = slot_size[victim][7:0];
        res.ev_swaps = ns;
        res.requeue = ns < swap_limit;
        slot_busy[victim] = 0;
      end
    end
    used = 0; holes = 0; cnt = 0; prev = 0;
    for (k = 0; k < UNITS; k++) begin
      if (unit_free[k]) begin
        if (!prev) holes++;
        prev = 1;
      end else begin
        used++;
        prev = 0;
      end
      if (slot_busy[k]) cnt++;
    end
    res.residents = cnt[7:0];
    res.holes = holes[6:0];
    res.used = used[7:0];
    return res;
  endfunction

  // Receiver hold-off counter.
  always @(negedge clk) begin
    if (!rst && hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Driver: present the next beat at the falling edge once the last is taken, and predict its result then.
  always @(negedge clk) begin
    if (!rst) begin
      out_ready <= (hold_cycles > 1) ? 1'b0 : (quiet_out || $urandom_range(99) >= 7);
      if (!in_valid || driving) begin
        if (pending_reqs.size() > 0 && !quiet_in &&
            (quiet_out || $urandom_range(99) >= 7)) begin
          in_valid <= 1'b1;
          process_id <= pending_reqs[0].pid;
          request_size <= pending_reqs[0].size;
          swaps_so_far <= pending_reqs[0].swaps;
          expected_results.push_back(predict_alloc(pending_reqs.pop_front()));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) driving <= in_valid && in_ready;

  // Monitor.
  always @(posedge clk) begin
    alloc_result_t exp_r, got;
    if (!rst && out_valid && out_ready) begin
      got = '{outcome, placed_start, evicted_id, evicted_size, evicted_swaps, requeue,
              resident_count, hole_count, used_units};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIT_POLICY) policy = val;
    else swap_limit = val;
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic push_req(input logic [7:0] p, input logic [7:0] s, input logic [1:0] w);
    request_t r;
    r.pid = p; r.size = s; r.swaps = w;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [7:0] rand_size();
    int unsigned c;
    c = $urandom_range(99);
    if (c < 70) return 8'($urandom_range(16, 1));
    if (c < 90) return 8'($urandom_range(64, 17));
    if (c < 97) return 8'($urandom_range(128, 65));
    return (c == 97) ? 8'd0 : 8'($urandom_range(255, 129));
  endfunction

  initial begin
    int ph;
    policy = POL_FIRST; swap_limit = 2'd3; placements = 0; resume_at = 0;
    for (int i = 0; i < UNITS; i++) begin
      unit_free[i] = 1; slot_busy[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    quiet_out = 1;
    // Directed: zero size, too large on empty memory, full memory, eviction, saturation.
    push_req(8'h00, 8'd0, 2'd0);
    push_req(8'hFF, 8'd129, 2'd3);
    push_req(8'hFF, 8'd255, 2'd3);
    push_req(8'h01, 8'd128, 2'd3);
    push_req(8'h02, 8'd1, 2'd0);
    push_req(8'h02, 8'd1, 2'd0);
    push_req(8'hAA, 8'd10, 2'd2);
    push_req(8'h55, 8'd20, 2'd1);
    push_req(8'h03, 8'd5, 2'd0);
    drain();
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_FIT_POLICY, p[1:0]);
      write_reg(CFG_MAX_SWAPS, (p == 0) ? 2'd1 : (p == 3 ? 2'd3 : 2'd2));
      push_req(8'h10 + p[7:0], 8'd30, 2'd1);
      push_req(8'h20 + p[7:0], 8'd8, 2'd0);
      push_req(8'h30 + p[7:0], 8'd40, 2'd3);
      push_req(8'h40 + p[7:0], 8'd90, 2'd2);
      drain();
    end
    quiet_out = 0;
    for (ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FIT_POLICY, 2'($urandom_range(3)));
      write_reg(CFG_MAX_SWAPS, 2'($urandom_range(3, 1)));
      if (ph == 2) quiet_out = 1;
      if (ph == 4) hold_cycles = 3000;
      for (int i = 0; i < 160; i++)
        push_req(8'($urandom_range(255)), rand_size(), 2'($urandom_range(3)));
      if (ph == 5) begin
        while (pending_reqs.size() > 80) @(negedge clk);
        quiet_in = 1;
        while (in_valid || expected_results.size() > 0) @(negedge clk);
        quiet_in = 0;
      end
      drain();
      quiet_out = 0;
    end
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/fpa_pkg.sv
sv/fpa_ram.sv
sv/fpa_hole_track.sv
sv/fit_policy_allocator_with_eviction_unit.sv
bench/fit_policy_allocator_with_eviction_unit_tb.sv
